// ----- src/hsa_pkg.sv -----
package hsa_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int UNIT          = 60 << HUE_FRAC_BITS;
    localparam int TURN          = 6 * UNIT;
    localparam int HUE_W         = $clog2(TURN);
    localparam int OFF_W         = 15;
    localparam int GAIN_W        = 9;
    localparam int GAIN_RESET    = 256;
    localparam int CH_W          = 8;
    localparam int T_W           = 11;
    localparam int HNUM_W        = $clog2(6 * 255 * UNIT + 1);
    localparam int SNUM_W        = 24;
    localparam int DIV_W         = (HNUM_W > SNUM_W) ? HNUM_W : SNUM_W;
    localparam int F_W           = $clog2(UNIT + 1);
    localparam int PX_W          = 16 + F_W;
    localparam int Y_W           = PX_W - HUE_FRAC_BITS - 2;
    localparam int RECIP_SH      = 24;
    localparam int RECIP15       = (1 << RECIP_SH) / 15;
    localparam int RECIPT        = (1 << RECIP_SH) / TURN;

    localparam logic CFG_HUE_OFFSET = 1'b0;
    localparam logic CFG_SAT_GAIN   = 1'b1;

    typedef struct packed {
        logic              vld;
        logic              grey;
        logic              black;
        logic [CH_W-1:0]   mx;
        logic [DIV_W-1:0]  hn;
        logic [DIV_W-1:0]  hq;
        logic [CH_W-1:0]   hr;
        logic [CH_W-1:0]   hd;
        logic [DIV_W-1:0]  sn;
        logic [DIV_W-1:0]  sq;
        logic [CH_W-1:0]   sr;
        logic [CH_W-1:0]   sd;
    } cell_t;

endpackage

// ----- src/hsv_hue_saturation_adjust_unit.sv -----
// Hue and saturation adjuster, one RGB888 pixel per word.
// s_axis: input pixel, tdata = {blue, green, red}, red in the low byte.
// m_axis: adjusted pixel, same packing.
// cfg: cfg_we writes cfg_data to register cfg_index at the clock edge
//   (0: hue offset, degrees x 64, taken modulo 360; 1: saturation gain, Q1.8).
// Throughput: one pixel per clock unless m_tready stalls the pipeline. The hue
// and saturation divisions run in a chain of restoring divider cells, one
// quotient bit per cell (24 cells), followed by seven arithmetic stages.
// After a write, the hue offset is reduced modulo one turn through a registered
// quotient and then a registered remainder, well inside the pipeline latency.
// Reset empties the pipeline, clearing its valid flags, and sets offset 0 and gain 1.0.
// When m_tready is low with a word waiting, the whole pipeline holds and
// s_tready drops; words already inside are kept, none are lost.
module hsv_hue_saturation_adjust_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // red_in, green_in, blue_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // red_out, green_out, blue_out
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [hsa_pkg::OFF_W-1:0]   cfg_data
);

    localparam logic [23:0] TURN24 = 24'(hsa_pkg::TURN);
    localparam logic [23:0] RECT   = 24'(hsa_pkg::RECIPT);
    localparam logic [hsa_pkg::T_W-1:0] T2 = 11'd2;
    localparam logic [hsa_pkg::T_W-1:0] T4 = 11'd4;
    localparam logic [hsa_pkg::T_W-1:0] T6 = 11'd6;

    logic [hsa_pkg::OFF_W-1:0]  hue_offset_reg;
    logic [hsa_pkg::GAIN_W-1:0] gain_reg;
    logic [7:0]                 off_q_reg;
    logic [hsa_pkg::HUE_W-1:0]  offr_reg;
    hsa_pkg::cell_t             prep_reg;
    hsa_pkg::cell_t             prep_next;
    hsa_pkg::cell_t             chain [0:hsa_pkg::DIV_W];

    logic        en;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [hsa_pkg::T_W-1:0] t;
    logic [38:0] oprod;
    logic [23:0] orem;
    logic        out_vld;
    logic [7:0]  ro;
    logic [7:0]  go;
    logic [7:0]  bo;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        r  = s_tdata[7:0];
        g  = s_tdata[15:8];
        b  = s_tdata[23:16];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d  = mx - mn;

        priority if (mx == r)
        begin
            t = (g >= b) ? hsa_pkg::T_W'(g - b) : T6 * hsa_pkg::T_W'(d) - hsa_pkg::T_W'(b - g);
        end
        else if (mx == g)
        begin
            t = (b >= r) ? T2 * hsa_pkg::T_W'(d) + hsa_pkg::T_W'(b - r)
                         : T2 * hsa_pkg::T_W'(d) - hsa_pkg::T_W'(r - b);
        end
        else
        begin
            t = (r >= g) ? T4 * hsa_pkg::T_W'(d) + hsa_pkg::T_W'(r - g)
                         : T4 * hsa_pkg::T_W'(d) - hsa_pkg::T_W'(g - r);
        end

        prep_next       = '0;
        prep_next.vld   = s_tvalid;
        prep_next.grey  = (d == 8'd0);
        prep_next.black = (mx == 8'd0);
        prep_next.mx    = mx;
        prep_next.hn    = hsa_pkg::DIV_W'(t) * hsa_pkg::DIV_W'(hsa_pkg::UNIT);
        prep_next.hd    = d;
        prep_next.sn    = hsa_pkg::DIV_W'({d, 16'd0} - {16'd0, d});
        prep_next.sd    = mx;

        oprod = hue_offset_reg * RECT;
        orem  = 24'(hue_offset_reg) - 24'(off_q_reg) * TURN24;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_offset_reg <= '0;
            gain_reg       <= hsa_pkg::GAIN_W'(hsa_pkg::GAIN_RESET);
            off_q_reg      <= '0;
            offr_reg       <= '0;
            prep_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hsa_pkg::CFG_HUE_OFFSET: hue_offset_reg <= cfg_data;
                    hsa_pkg::CFG_SAT_GAIN:   gain_reg <= cfg_data[hsa_pkg::GAIN_W-1:0];
                    default:                 gain_reg <= gain_reg;
                endcase
            end
            off_q_reg <= oprod[hsa_pkg::RECIP_SH +: 8];
            offr_reg  <= (orem >= TURN24) ? hsa_pkg::HUE_W'(orem - TURN24)
                                          : orem[hsa_pkg::HUE_W-1:0];
            if (en)
            begin
                prep_reg <= prep_next;
            end
        end
    end

    assign chain[0] = prep_reg;

    for (genvar i = 0; i < hsa_pkg::DIV_W; i++)
    begin : g_cell
        hsa_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    hsa_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .din     (chain[hsa_pkg::DIV_W]),
        .offr    (offr_reg),
        .gain    (gain_reg),
        .out_vld (out_vld),
        .red     (ro),
        .green   (go),
        .blue    (bo)
    );

    assign m_tvalid = out_vld;
    assign m_tdata  = {bo, go, ro};

endmodule

// ----- src/hsa_div_cell.sv -----
module hsa_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  hsa_pkg::cell_t din,
    output hsa_pkg::cell_t dout
);

    hsa_pkg::cell_t cell_reg;
    hsa_pkg::cell_t cell_next;
    logic [hsa_pkg::CH_W:0] h_trial;
    logic [hsa_pkg::CH_W:0] s_trial;
    logic                   h_ge;
    logic                   s_ge;

    always_comb
    begin
        h_trial = {din.hr, din.hn[hsa_pkg::DIV_W-1]};
        s_trial = {din.sr, din.sn[hsa_pkg::DIV_W-1]};
        h_ge    = h_trial >= {1'b0, din.hd};
        s_ge    = s_trial >= {1'b0, din.sd};
        cell_next    = din;
        cell_next.hn = {din.hn[hsa_pkg::DIV_W-2:0], 1'b0};
        cell_next.sn = {din.sn[hsa_pkg::DIV_W-2:0], 1'b0};
        cell_next.hq = {din.hq[hsa_pkg::DIV_W-2:0], h_ge};
        cell_next.sq = {din.sq[hsa_pkg::DIV_W-2:0], s_ge};
        cell_next.hr = h_ge ? hsa_pkg::CH_W'(h_trial - {1'b0, din.hd})
                            : h_trial[hsa_pkg::CH_W-1:0];
        cell_next.sr = s_ge ? hsa_pkg::CH_W'(s_trial - {1'b0, din.sd})
                            : s_trial[hsa_pkg::CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ----- src/hsa_post.sv -----
module hsa_post (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  hsa_pkg::cell_t             din,
    input  logic [hsa_pkg::HUE_W-1:0]  offr,
    input  logic [hsa_pkg::GAIN_W-1:0] gain,
    output logic                       out_vld,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue
);

    localparam logic [hsa_pkg::HUE_W:0]  TURN_C = (hsa_pkg::HUE_W+1)'(hsa_pkg::TURN);
    localparam logic [hsa_pkg::HUE_W-1:0] U1 = hsa_pkg::HUE_W'(hsa_pkg::UNIT);
    localparam logic [hsa_pkg::HUE_W-1:0] U2 = hsa_pkg::HUE_W'(2 * hsa_pkg::UNIT);
    localparam logic [hsa_pkg::HUE_W-1:0] U3 = hsa_pkg::HUE_W'(3 * hsa_pkg::UNIT);
    localparam logic [hsa_pkg::HUE_W-1:0] U4 = hsa_pkg::HUE_W'(4 * hsa_pkg::UNIT);
    localparam logic [hsa_pkg::HUE_W-1:0] U5 = hsa_pkg::HUE_W'(5 * hsa_pkg::UNIT);
    localparam logic [hsa_pkg::F_W-1:0]   UF = hsa_pkg::F_W'(hsa_pkg::UNIT);
    localparam logic [20:0] R15 = 21'(hsa_pkg::RECIP15);

    logic [6:0] vld_reg;

    logic [hsa_pkg::HUE_W-1:0] a_h2_reg;
    logic [15:0]               a_s2_reg;
    logic [15:0]               a_v_reg;
    logic [31:0]               b_pc_reg;
    logic [2:0]                b_k_reg;
    logic [hsa_pkg::F_W-1:0]   b_f_reg;
    logic [15:0]               b_v_reg;
    logic [15:0]               c_c_reg;
    logic [2:0]                c_k_reg;
    logic [hsa_pkg::F_W-1:0]   c_f_reg;
    logic [15:0]               c_v_reg;
    logic [hsa_pkg::PX_W-1:0]  d_px_reg;
    logic [15:0]               d_c_reg;
    logic [15:0]               d_m_reg;
    logic [2:0]                d_k_reg;
    logic [15:0]               e_q0_reg;
    logic [hsa_pkg::Y_W-1:0]   e_y_reg;
    logic [15:0]               e_c_reg;
    logic [15:0]               e_m_reg;
    logic [2:0]                e_k_reg;
    logic [15:0]               f_x_reg;
    logic [15:0]               f_c_reg;
    logic [15:0]               f_m_reg;
    logic [2:0]                f_k_reg;
    logic [7:0]                r_reg;
    logic [7:0]                g_reg;
    logic [7:0]                b_reg;

    logic [hsa_pkg::HUE_W-1:0] h;
    logic [15:0]               s;
    logic [hsa_pkg::HUE_W:0]   hsum;
    logic [hsa_pkg::HUE_W-1:0] h2;
    logic [24:0]               sp;
    logic [15:0]               s2;
    logic [2:0]                k;
    logic [hsa_pkg::HUE_W-1:0] kbase;
    logic [16:0]               cr;
    logic [15:0]               cq;
    logic [hsa_pkg::F_W-1:0]   fp;
    logic [hsa_pkg::Y_W-1:0]   y;
    logic [hsa_pkg::Y_W+20:0]  yp;
    logic [hsa_pkg::Y_W-1:0]   yr;
    logic [15:0]               ro;
    logic [15:0]               go;
    logic [15:0]               bo;

    function automatic logic [7:0] chan(input logic [15:0] ch, input logic [15:0] m);
        logic [16:0] sm;
        logic [15:0] sc;
        logic [15:0] t;
        begin
            sm = {1'b0, ch} + {1'b0, m};
            sc = sm[16] ? 16'hFFFF : sm[15:0];
            t  = sc - {8'd0, sc[15:8]};
            return t[15:8];
        end
    endfunction

    always_comb
    begin
        h    = din.grey ? '0 : din.hq[hsa_pkg::HUE_W-1:0];
        s    = din.black ? '0 : din.sq[15:0];
        hsum = {1'b0, h} + {1'b0, offr};
        h2   = (hsum >= TURN_C) ? hsa_pkg::HUE_W'(hsum - TURN_C) : hsum[hsa_pkg::HUE_W-1:0];
        sp   = s * gain;
        s2   = sp[24] ? 16'hFFFF : sp[23:8];

        priority if (a_h2_reg >= U5)
        begin
            k = 3'd5; kbase = U5;
        end
        else if (a_h2_reg >= U4)
        begin
            k = 3'd4; kbase = U4;
        end
        else if (a_h2_reg >= U3)
        begin
            k = 3'd3; kbase = U3;
        end
        else if (a_h2_reg >= U2)
        begin
            k = 3'd2; kbase = U2;
        end
        else if (a_h2_reg >= U1)
        begin
            k = 3'd1; kbase = U1;
        end
        else
        begin
            k = 3'd0; kbase = '0;
        end

        cr = {1'b0, b_pc_reg[15:0]} + {1'b0, b_pc_reg[31:16]};
        cq = b_pc_reg[31:16] + ((cr >= 17'd131070) ? 16'd2 : (cr >= 17'd65535) ? 16'd1 : 16'd0);

        fp = c_k_reg[0] ? (UF - c_f_reg) : c_f_reg;

        y  = d_px_reg[hsa_pkg::HUE_FRAC_BITS+2 +: hsa_pkg::Y_W];
        yp = y * R15;

        yr = e_y_reg - hsa_pkg::Y_W'(e_q0_reg) * hsa_pkg::Y_W'(15);

        unique case (f_k_reg)
            3'd0:    begin ro = f_c_reg; go = f_x_reg; bo = '0;      end
            3'd1:    begin ro = f_x_reg; go = f_c_reg; bo = '0;      end
            3'd2:    begin ro = '0;      go = f_c_reg; bo = f_x_reg; end
            3'd3:    begin ro = '0;      go = f_x_reg; bo = f_c_reg; end
            3'd4:    begin ro = f_x_reg; go = '0;      bo = f_c_reg; end
            default: begin ro = f_c_reg; go = '0;      bo = f_x_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], din.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_h2_reg <= h2;
            a_s2_reg <= s2;
            a_v_reg  <= {din.mx, din.mx};

            b_pc_reg <= a_v_reg * a_s2_reg;
            b_k_reg  <= k;
            b_f_reg  <= hsa_pkg::F_W'(a_h2_reg - kbase);
            b_v_reg  <= a_v_reg;

            c_c_reg  <= cq;
            c_k_reg  <= b_k_reg;
            c_f_reg  <= b_f_reg;
            c_v_reg  <= b_v_reg;

            d_px_reg <= c_c_reg * fp;
            d_c_reg  <= c_c_reg;
            d_m_reg  <= c_v_reg - c_c_reg;
            d_k_reg  <= c_k_reg;

            e_q0_reg <= yp[hsa_pkg::RECIP_SH +: 16];
            e_y_reg  <= y;
            e_c_reg  <= d_c_reg;
            e_m_reg  <= d_m_reg;
            e_k_reg  <= d_k_reg;

            f_x_reg  <= e_q0_reg + ((yr >= hsa_pkg::Y_W'(15)) ? 16'd1 : 16'd0);
            f_c_reg  <= e_c_reg;
            f_m_reg  <= e_m_reg;
            f_k_reg  <= e_k_reg;

            r_reg    <= chan(ro, f_m_reg);
            g_reg    <= chan(go, f_m_reg);
            b_reg    <= chan(bo, f_m_reg);
        end
    end

    assign out_vld = vld_reg[6];
    assign red     = r_reg;
    assign green   = g_reg;
    assign blue    = b_reg;

endmodule

// ----- bench/hsa_checker.sv -----
`timescale 1ns / 1ps

module hsa_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [23:0]               s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [23:0]               m_tdata,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [hsa_pkg::OFF_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        pixels_in
);
    import hsa_pkg::*;

    logic [OFF_W-1:0]  hue_off;
    logic [GAIN_W-1:0] sat_gain;
    logic [23:0]       expected_pixels[$];

    function automatic logic [23:0] adjust_pixel(logic [7:0] r8, logic [7:0] g8,
                                                   logic [7:0] b8, logic [OFF_W-1:0] off,
                                                   logic [GAIN_W-1:0] gain);
        longint unsigned r, g, b, u, t, mx, mn, d, v, s, h, num, c, m, x, f, k;
        longint unsigned ro, go, bo;
        logic [7:0] o[3];
        longint unsigned ch[3];
        r = r8; g = g8; b = b8;
        u = 60 << HUE_FRAC_BITS;
        t = 6 * u;
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        d = mx - mn;
        v = mx * 257;
        s = (mx > 0) ? (d * 65535) / mx : 0;
        h = 0;
        if (d != 0)
        begin
            if (mx == r)
                num = (g >= b) ? u * (g - b) : 6 * d * u - u * (b - g);
            else if (mx == g)
                num = (b >= r) ? 2 * d * u + u * (b - r) : 2 * d * u - u * (r - b);
            else
                num = (r >= g) ? 4 * d * u + u * (r - g) : 4 * d * u - u * (g - r);
            h = num / d;
        end
        h = (h % t + longint'(off) % t) % t;
        s = (s * gain) / 256;
        if (s > 65535) s = 65535;
        c = (v * s) / 65535;
        m = v - c;
        k = h / u;
        f = h - k * u;
        x = ((k & 1) == 0) ? (c * f) / u : (c * (u - f)) / u;
        case (k)
            0: begin ro = c; go = x; bo = 0; end
            1: begin ro = x; go = c; bo = 0; end
            2: begin ro = 0; go = c; bo = x; end
            3: begin ro = 0; go = x; bo = c; end
            4: begin ro = x; go = 0; bo = c; end
            default: begin ro = c; go = 0; bo = x; end
        endcase
        ch[0] = ro + m; ch[1] = go + m; ch[2] = bo + m;
        for (int i = 0; i < 3; i++)
        begin
            if (ch[i] > 65535) ch[i] = 65535;
            o[i] = 8'(ch[i] / 257);
        end
        return {o[2], o[1], o[0]};
    endfunction

    assign pending = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] exp_px;
        if (!rst_n)
        begin
            hue_off    <= '0;
            sat_gain   <= GAIN_W'(GAIN_RESET);
            fail_count <= 0;
            pixels_in  <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_HUE_OFFSET)
                    hue_off <= cfg_data;
                else
                    sat_gain <= cfg_data[GAIN_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                expected_pixels.push_back(adjust_pixel(s_tdata[7:0], s_tdata[15:8],
                                                       s_tdata[23:16], hue_off, sat_gain));
                pixels_in <= pixels_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (exp_px[7:0] !== m_tdata[7:0])
                        $error("red_out: expected %0d, got %0d", exp_px[7:0], m_tdata[7:0]);
                    if (exp_px[15:8] !== m_tdata[15:8])
                        $error("green_out: expected %0d, got %0d",
                               exp_px[15:8], m_tdata[15:8]);
                    if (exp_px[23:16] !== m_tdata[23:16])
                        $error("blue_out: expected %0d, got %0d",
                               exp_px[23:16], m_tdata[23:16]);
                    if (exp_px !== m_tdata)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// ----- bench/hsv_hue_saturation_adjust_unit_tb.sv -----
`timescale 1ns / 1ps

module hsv_hue_saturation_adjust_unit_tb;
    import hsa_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;   // red_in, green_in, blue_in
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // red_out, green_out, blue_out
    logic               cfg_we;
    logic               cfg_index;
    logic [OFF_W-1:0]   cfg_data;
    int                 fail_count;
    int                 pending;
    int                 pixels_in;
    int                 idle_pct;
    int                 stall_pct;
    int                 settings_done;

    hsv_hue_saturation_adjust_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hsa_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .pixels_in  (pixels_in)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver; one long hold-off once the stream is well under way
    initial
    begin
        bit held;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && pixels_in >= 700)
            begin
                held = 1;
                m_tready <= 1'b0;
                for (int n = 0; n < 300; n++)
                    @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        bit taken;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic write_reg(logic idx, logic [OFF_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_done++;
    endtask

    task automatic random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        case ($urandom_range(9))
            0: begin g = r; b = r; end
            1: g = r;
            2: b = g;
            3: begin r = 8'($urandom_range(1) * 255); g = 8'($urandom_range(1) * 255); end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial
    begin
        logic [OFF_W-1:0] offs[4];
        logic [OFF_W-1:0] gains[4];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_HUE_OFFSET;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        settings_done = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(200, 100, 150);
        send_pixel(10, 200, 90);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 1);
        write_reg(CFG_HUE_OFFSET, 15'd23039);
        write_reg(CFG_SAT_GAIN, 15'd511);
        send_pixel(255, 0, 0);
        send_pixel(200, 100, 150);
        send_pixel(90, 10, 200);
        send_pixel(255, 255, 255);
        write_reg(CFG_HUE_OFFSET, 15'd32767);
        write_reg(CFG_SAT_GAIN, 15'd0);
        send_pixel(255, 0, 0);
        send_pixel(30, 220, 7);
        write_reg(CFG_HUE_OFFSET, 15'd23040);
        write_reg(CFG_SAT_GAIN, 15'd384);
        send_pixel(255, 0, 0);
        send_pixel(0, 128, 255);

        offs[0] = 15'd0;     gains[0] = 15'd256;
        offs[1] = 15'd11520; gains[1] = 15'd511;
        offs[2] = 15'($urandom_range(32767)); gains[2] = 15'($urandom_range(511));
        offs[3] = 15'd7680;  gains[3] = 15'd1;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_HUE_OFFSET, offs[p]);
            write_reg(CFG_SAT_GAIN, gains[p]);
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int i = 0; i < 325; i++)
                random_pixel();
            s_tvalid <= 1'b0;
        end

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Pixels checked: %0d over %0d register writes,", pixels_in, settings_done);
        $display("covering grey, black, ties, wrap of the hue offset and gain saturation.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
